// ===== hdl/fmbs_pkg.sv =====
// Shared types and constants for the FM-index backward search block.
package fmbs_pkg;

	localparam int TEXT_DEPTH_DEF    = 4096;
	localparam int ALPHABET_SIZE_DEF = 256;
	localparam int SYM_W             = 8;
	localparam int ROW_W             = 12;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_QUERY = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic bwt_we;
		logic cnt_we;
		logic cnt_clear;
	} store_ctl_t;

endpackage

// ===== hdl/fmbs_store.sv =====
// BWT text memory and per-symbol count memory with per-entry valid bits.
module fmbs_store #(
	parameter int TEXT_DEPTH    = fmbs_pkg::TEXT_DEPTH_DEF,
	parameter int ALPHABET_SIZE = fmbs_pkg::ALPHABET_SIZE_DEF,
	parameter int AW            = $clog2(TEXT_DEPTH),
	parameter int SW            = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1,
	parameter int CNT_W         = $clog2(TEXT_DEPTH + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  fmbs_pkg::store_ctl_t     ctl,
	input  logic [AW-1:0]            bwt_waddr,
	input  logic [fmbs_pkg::SYM_W-1:0] bwt_wdata,
	input  logic [AW-1:0]            bwt_raddr,
	output logic [fmbs_pkg::SYM_W-1:0] bwt_rdata,
	input  logic [SW-1:0]            cnt_waddr,
	input  logic [CNT_W-1:0]         cnt_wdata,
	input  logic [SW-1:0]            cnt_raddr,
	output logic [CNT_W-1:0]         cnt_rdata
);

	logic [fmbs_pkg::SYM_W-1:0] bwt_mem [TEXT_DEPTH];
	logic [CNT_W-1:0]           cnt_mem [ALPHABET_SIZE];
	logic [ALPHABET_SIZE-1:0]   cnt_vld_q;
	logic [CNT_W-1:0]           cnt_rd_q;
	logic                       cnt_rd_vld_q;

	always_ff @(posedge clk) begin
		if (ctl.bwt_we) begin
			bwt_mem[bwt_waddr] <= bwt_wdata;
		end
		bwt_rdata <= bwt_mem[bwt_raddr];
	end

	always_ff @(posedge clk) begin
		if (ctl.cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		cnt_rd_q <= cnt_mem[cnt_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q    <= '0;
			cnt_rd_vld_q <= 1'b0;
		end else begin
			cnt_rd_vld_q <= cnt_vld_q[cnt_raddr];
			if (ctl.cnt_clear) begin
				cnt_vld_q <= '0;
			end else if (ctl.cnt_we) begin
				cnt_vld_q[cnt_waddr] <= 1'b1;
			end
		end
	end

	assign cnt_rdata = cnt_rd_vld_q ? cnt_rd_q : '0;

endmodule

// ===== hdl/fm_index_backward_search.sv =====
// Top level of the FM-index exact-match backward search engine.
// Load: text write and count read on accept, then the count write in ST_LOAD. Clear and empty-range query: no sweep.
// Live query symbol: a one-entry-per-cycle sweep of the text memory up to max(symbol, end row)
// builds C[c] and both ranks; last adds a pass through ST_EMIT to load the result.
// One item in flight; a result waits in the output register while the next item runs.
// Reset clears text length, row range and all symbol counts at once (no sweep).
module fm_index_backward_search #(
	parameter int TEXT_DEPTH    = fmbs_pkg::TEXT_DEPTH_DEF,
	parameter int ALPHABET_SIZE = fmbs_pkg::ALPHABET_SIZE_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 req_type,
	input  logic [fmbs_pkg::SYM_W-1:0] symbol,
	input  logic                       first,
	input  logic                       last,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       found,
	output logic [fmbs_pkg::ROW_W-1:0] low_row,
	output logic [fmbs_pkg::ROW_W-1:0] high_row
);

	localparam int SYM_W = fmbs_pkg::SYM_W;
	localparam int ROW_W = fmbs_pkg::ROW_W;
	localparam int AW    = $clog2(TEXT_DEPTH);
	localparam int SW    = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
	localparam int LW    = $clog2(TEXT_DEPTH + 1);
	localparam int IW    = (LW > SYM_W) ? LW : SYM_W;
	localparam int RW    = (LW > ROW_W) ? LW : ROW_W;
	localparam logic [SYM_W:0] ALPHA_LIM = (SYM_W + 1)'(ALPHABET_SIZE);
	localparam logic [LW-1:0]  DEPTH_LIM = LW'(TEXT_DEPTH);

	fmbs_pkg::state_t     state_q, state_d;
	fmbs_pkg::store_ctl_t ctl;
	fmbs_pkg::req_t       req;

	logic [LW-1:0]    len_q, sp_q, ep_q;
	logic [SYM_W-1:0] sym_q;
	logic             last_q;
	logic [IW-1:0]    i_q, lim_q;
	logic [LW-1:0]    base_q, rsp_q, rep_q;
	logic             vld_s1, cnt_s1, sp_s1, ep_s1;

	logic [AW-1:0]    bwt_raddr;
	logic [SYM_W-1:0] bwt_rdata;
	logic [SW-1:0]    cnt_raddr;
	logic [LW-1:0]    cnt_rdata;

	logic             out_valid_q, found_q;
	logic [ROW_W-1:0] low_q, high_q;

	logic             in_acc, sym_ok, load_ok, q_live, issue, scan_done, out_free;
	logic [LW-1:0]    sp0, ep0;
	logic [IW-1:0]    lim0;
	logic [RW-1:0]    sp_ext, epm1_ext;

	assign req      = fmbs_pkg::req_t'(req_type);
	assign in_acc   = in_valid && !in_stall;
	assign sym_ok   = {1'b0, symbol} < ALPHA_LIM;
	assign load_ok  = (len_q < DEPTH_LIM) && sym_ok;
	assign sp0      = first ? LW'(1) : sp_q;
	assign ep0      = first ? len_q : ep_q;
	assign q_live   = sp0 < ep0;
	assign lim0     = (IW'(ep0) > IW'(symbol)) ? IW'(ep0) : IW'(symbol);
	assign issue    = (state_q == fmbs_pkg::ST_SCAN) && (i_q < lim_q);
	assign scan_done = (state_q == fmbs_pkg::ST_SCAN) && !issue && !vld_s1;
	assign out_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fmbs_pkg::ST_IDLE: begin
				if (in_valid) begin
					unique case (req)
						fmbs_pkg::REQ_LOAD: begin
							if (load_ok) state_d = fmbs_pkg::ST_LOAD;
						end
						fmbs_pkg::REQ_QUERY: begin
							if (q_live && sym_ok) state_d = fmbs_pkg::ST_SCAN;
							else if (last) state_d = fmbs_pkg::ST_EMIT;
						end
						default: state_d = fmbs_pkg::ST_IDLE;
					endcase
				end
			end
			fmbs_pkg::ST_LOAD: state_d = fmbs_pkg::ST_IDLE;
			fmbs_pkg::ST_SCAN: begin
				if (scan_done) state_d = last_q ? fmbs_pkg::ST_EMIT : fmbs_pkg::ST_IDLE;
			end
			fmbs_pkg::ST_EMIT: begin
				if (out_free) state_d = fmbs_pkg::ST_IDLE;
			end
			default: state_d = fmbs_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall      = (state_q != fmbs_pkg::ST_IDLE);
		ctl.bwt_we    = in_acc && (req == fmbs_pkg::REQ_LOAD) && load_ok;
		ctl.cnt_we    = (state_q == fmbs_pkg::ST_LOAD);
		ctl.cnt_clear = in_acc && (req == fmbs_pkg::REQ_CLEAR);
		bwt_raddr     = i_q[AW-1:0];
		cnt_raddr     = (state_q == fmbs_pkg::ST_IDLE) ? symbol[SW-1:0] : i_q[SW-1:0];
	end

	fmbs_store #(
		.TEXT_DEPTH    (TEXT_DEPTH),
		.ALPHABET_SIZE (ALPHABET_SIZE),
		.AW            (AW),
		.SW            (SW),
		.CNT_W         (LW)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.bwt_waddr (len_q[AW-1:0]),
		.bwt_wdata (symbol),
		.bwt_raddr (bwt_raddr),
		.bwt_rdata (bwt_rdata),
		.cnt_waddr (sym_q[SW-1:0]),
		.cnt_wdata (cnt_rdata + LW'(1)),
		.cnt_raddr (cnt_raddr),
		.cnt_rdata (cnt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fmbs_pkg::ST_IDLE;
			len_q   <= '0;
			sp_q    <= '0;
			ep_q    <= '0;
			i_q     <= '0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			if (issue) begin
				i_q <= i_q + IW'(1);
			end
			if (in_acc) begin
				unique case (req)
					fmbs_pkg::REQ_LOAD: ;
					fmbs_pkg::REQ_CLEAR: len_q <= '0;
					fmbs_pkg::REQ_QUERY: begin
						i_q <= '0;
						if (q_live && !sym_ok) begin
							sp_q <= len_q;
							ep_q <= len_q;
						end else begin
							sp_q <= sp0;
							ep_q <= ep0;
						end
					end
					default: ;
				endcase
			end
			if (state_q == fmbs_pkg::ST_LOAD) begin
				len_q <= len_q + LW'(1);
			end
			if (scan_done) begin
				sp_q <= base_q + rsp_q;
				ep_q <= base_q + rep_q;
			end
		end
	end

	// item payload and scan accumulators; ranks only count rows below the text length
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sym_q  <= symbol;
			last_q <= last;
			lim_q  <= lim0;
			base_q <= '0;
			rsp_q  <= '0;
			rep_q  <= '0;
		end
		cnt_s1 <= i_q < IW'(sym_q);
		sp_s1  <= (i_q < IW'(sp_q)) && (i_q < IW'(len_q));
		ep_s1  <= (i_q < IW'(ep_q)) && (i_q < IW'(len_q));
		if (vld_s1) begin
			if (cnt_s1) base_q <= base_q + cnt_rdata;
			if (sp_s1 && bwt_rdata == sym_q) rsp_q <= rsp_q + LW'(1);
			if (ep_s1 && bwt_rdata == sym_q) rep_q <= rep_q + LW'(1);
		end
	end

	assign sp_ext   = RW'(sp_q);
	assign epm1_ext = RW'(ep_q - LW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == fmbs_pkg::ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == fmbs_pkg::ST_EMIT && out_free) begin
			found_q <= sp_q < ep_q;
			low_q   <= (sp_q < ep_q) ? sp_ext[ROW_W-1:0] : '0;
			high_q  <= (sp_q < ep_q) ? epm1_ext[ROW_W-1:0] : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign low_row   = low_q;
	assign high_row  = high_q;

endmodule
